[rtl/cct_pkg.sv]
// Shared types, event codes and constants for the cooker countdown thermostat.
// No dependencies.
`timescale 1ns / 1ps

package cct_pkg;

	localparam int CCT_MAX_HOURS = 24;

	localparam int HRS_W  = 5;
	localparam int MINS_W = 6;
	localparam int SECS_W = 6;
	localparam int UNIT_W = 3;
	localparam int REQ_W  = 3;
	localparam int TEMP_W = 17;
	localparam int SP_W   = 15;
	localparam int BAND_W = 14;

	localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_START  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_STOP   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_MODE   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_INC    = 3'd4;
	localparam logic [REQ_W-1:0] REQ_DEC    = 3'd5;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SAMPLE = 3'd7;

	localparam logic [UNIT_W-1:0] UNIT_1S  = 3'd0;
	localparam logic [UNIT_W-1:0] UNIT_10S = 3'd1;
	localparam logic [UNIT_W-1:0] UNIT_1M  = 3'd2;
	localparam logic [UNIT_W-1:0] UNIT_10M = 3'd3;
	localparam logic [UNIT_W-1:0] UNIT_1H  = 3'd4;

	typedef struct packed {
		logic [HRS_W-1:0]  hrs;
		logic [MINS_W-1:0] mins;
		logic [SECS_W-1:0] secs;
	} hms_t;

endpackage

[rtl/cct_time_adj.sv]
// Adds or subtracts one adjust unit to an hh:mm:ss time, field by field with
// carry and borrow, saturating at zero and at max_hours:00:00. Uses cct_pkg.
`timescale 1ns / 1ps

module cct_time_adj import cct_pkg::*; #(
	parameter int MAX_HOURS = CCT_MAX_HOURS
) (
	input  hms_t              cur,
	input  logic [UNIT_W-1:0] unit,
	input  logic              sub,
	output hms_t              res
);

	localparam logic [HRS_W:0] MAX_H = (HRS_W+1)'(MAX_HOURS);

	logic [6:0]     sec_step;
	logic [6:0]     min_step;
	logic [HRS_W:0] hr_step;

	logic [6:0]     s_raw, m_raw;
	logic [HRS_W:0] h_raw;
	logic           s_cy, m_cy;
	logic [SECS_W-1:0] s_new;
	logic [MINS_W-1:0] m_new;

	always_comb begin
		sec_step = 7'd0;
		min_step = 7'd0;
		hr_step  = '0;
		case (unit)
			UNIT_1S:  sec_step = 7'd1;
			UNIT_10S: sec_step = 7'd10;
			UNIT_1M:  min_step = 7'd1;
			UNIT_10M: min_step = 7'd10;
			default:  hr_step  = (HRS_W+1)'(1);
		endcase
	end

	always_comb begin
		res = cur;
		if (sub) begin
			s_raw = {1'b0, cur.secs} - sec_step;
			s_cy  = s_raw[6];
			s_new = s_cy ? SECS_W'(s_raw + 7'd60) : s_raw[SECS_W-1:0];
			m_raw = {1'b0, cur.mins} - min_step - {6'd0, s_cy};
			m_cy  = m_raw[6];
			m_new = m_cy ? MINS_W'(m_raw + 7'd60) : m_raw[MINS_W-1:0];
			h_raw = {1'b0, cur.hrs} - hr_step - {{HRS_W{1'b0}}, m_cy};
			if (h_raw[HRS_W])
				res = '0;
			else
				res = '{hrs: h_raw[HRS_W-1:0], mins: m_new, secs: s_new};
		end else begin
			s_raw = {1'b0, cur.secs} + sec_step;
			s_cy  = (s_raw >= 7'd60);
			s_new = s_cy ? SECS_W'(s_raw - 7'd60) : s_raw[SECS_W-1:0];
			m_raw = {1'b0, cur.mins} + min_step + {6'd0, s_cy};
			m_cy  = (m_raw >= 7'd60);
			m_new = m_cy ? MINS_W'(m_raw - 7'd60) : m_raw[MINS_W-1:0];
			h_raw = {1'b0, cur.hrs} + hr_step + {{HRS_W{1'b0}}, m_cy};
			if ((h_raw > MAX_H) || ((h_raw == MAX_H) && ((|m_new) || (|s_new))))
				res = '{hrs: MAX_H[HRS_W-1:0], mins: '0, secs: '0};
			else
				res = '{hrs: h_raw[HRS_W-1:0], mins: m_new, secs: s_new};
		end
	end

endmodule

[rtl/cct_thermo.sv]
// Hysteresis thermostat decision for one temperature sample.
// Uses cct_pkg.
`timescale 1ns / 1ps

module cct_thermo import cct_pkg::*; (
	input  logic [TEMP_W-1:0] temp,
	input  logic [SP_W-1:0]   sp,
	input  logic [BAND_W-1:0] band,
	input  logic              heat_cur,
	output logic              heat_nxt
);

	logic [TEMP_W-1:0] upper;

	assign upper = TEMP_W'(sp) + TEMP_W'(band);

	always_comb begin
		if (temp <= TEMP_W'(sp))
			heat_nxt = 1'b1;
		else if (temp >= upper)
			heat_nxt = 1'b0;
		else
			heat_nxt = heat_cur;
	end

endmodule

[rtl/cooking_countdown_thermostat.sv]
// Cooker countdown timer with hysteresis thermostat, top level.
// Each event is registered in the input stage, then its result in the state registers.
// Throughput: one event per cycle; the input stage stalls only while the
// output register holds a beat not yet taken.
// Reset (arst_n low): time 00:00:00, one second unit, stopped, heater off, band 0.
// Uses cct_pkg, cct_time_adj and cct_thermo.
`timescale 1ns / 1ps

module cooking_countdown_thermostat import cct_pkg::*; #(
	parameter int MAX_HOURS = CCT_MAX_HOURS
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [BAND_W-1:0] hysteresis_band,

	input  logic              in_valid,
	output logic              in_ready,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [TEMP_W-1:0] temperature,
	input  logic [SP_W-1:0]   setpoint,

	output logic              out_valid,
	input  logic              out_ready,
	output logic [HRS_W-1:0]  hours_left,
	output logic [MINS_W-1:0] minutes_left,
	output logic [SECS_W-1:0] seconds_left,
	output logic [UNIT_W-1:0] adjust_unit,
	output logic              running,
	output logic              cooking_active,
	output logic              heater_on,
	output logic              done_pulse
);

	logic [BAND_W-1:0] band_q;

	logic              valid_s1;
	logic [REQ_W-1:0]  req_s1;
	logic [TEMP_W-1:0] temp_s1;
	logic [SP_W-1:0]   sp_s1;

	hms_t              time_q;
	logic [UNIT_W-1:0] unit_q;
	logic              run_q;
	logic              heat_q;

	logic              out_valid_q;
	logic              active_q;
	logic              done_q;

	logic              advance;
	hms_t              adj_time;
	logic [UNIT_W-1:0] adj_unit;
	logic              adj_sub;
	logic              heat_sample;

	hms_t              time_d;
	logic [UNIT_W-1:0] unit_d;
	logic              run_d;
	logic              heat_d;
	logic              done_d;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;

	assign adj_unit = (req_s1 == REQ_TICK) ? UNIT_1S : unit_q;
	assign adj_sub  = (req_s1 != REQ_INC);

	cct_time_adj #(
		.MAX_HOURS(MAX_HOURS)
	) u_time_adj (
		.cur  (time_q),
		.unit (adj_unit),
		.sub  (adj_sub),
		.res  (adj_time)
	);

	cct_thermo u_thermo (
		.temp     (temp_s1),
		.sp       (sp_s1),
		.band     (band_q),
		.heat_cur (heat_q),
		.heat_nxt (heat_sample)
	);

	always_comb begin
		time_d = time_q;
		unit_d = unit_q;
		run_d  = run_q;
		heat_d = heat_q;
		done_d = 1'b0;
		case (req_s1)
			REQ_TICK: begin
				if (run_q && (|time_q)) begin
					time_d = adj_time;
					done_d = ~|adj_time;
				end
			end
			REQ_START: run_d = 1'b1;
			REQ_STOP: begin
				run_d  = 1'b0;
				heat_d = 1'b0;
			end
			REQ_MODE: unit_d = (unit_q >= UNIT_1H) ? UNIT_1S : unit_q + 3'd1;
			REQ_INC, REQ_DEC: time_d = adj_time;
			REQ_CLEAR: begin
				time_d = '0;
				run_d  = 1'b0;
				heat_d = 1'b0;
			end
			default: heat_d = heat_sample;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			band_q <= hysteresis_band;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1  <= req_type;
			temp_s1 <= temperature;
			sp_s1   <= setpoint;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q      <= '0;
			unit_q      <= UNIT_1S;
			run_q       <= 1'b0;
			heat_q      <= 1'b0;
			out_valid_q <= 1'b0;
			active_q    <= 1'b0;
			done_q      <= 1'b0;
		end else if (advance) begin
			time_q      <= time_d;
			unit_q      <= unit_d;
			run_q       <= run_d;
			heat_q      <= heat_d;
			out_valid_q <= 1'b1;
			active_q    <= run_d && (|time_d);
			done_q      <= done_d;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// state registers double as the result beat
	assign out_valid      = out_valid_q;
	assign hours_left     = time_q.hrs;
	assign minutes_left   = time_q.mins;
	assign seconds_left   = time_q.secs;
	assign adjust_unit    = unit_q;
	assign running        = run_q;
	assign cooking_active = active_q;
	assign heater_on      = heat_q;
	assign done_pulse     = done_q;

endmodule
